### sv/sdt_section_parser_core_macros.svh
// Assertion macros shared by the service description table parser checkers
`ifndef SDT_SECTION_PARSER_CORE_MACROS_SVH
`define SDT_SECTION_PARSER_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SDT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/sdt_pkg.sv
// Package: record kinds, record type and register defaults of the SDT section parser
package sdt_pkg;

    localparam int unsigned ByteW     = 8;
    localparam int unsigned CfgIndexW = 1;

    localparam logic [ByteW-1:0] ActualTableIdReset = 8'd66;
    localparam logic [ByteW-1:0] OtherTableIdReset  = 8'd70;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_ACTUAL_TABLE_ID = 1'b0,
        CFG_OTHER_TABLE_ID  = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_SERVICE = 3'd1,
        KIND_END     = 3'd2,
        KIND_BAD_ID  = 3'd3,
        KIND_SYNTAX  = 3'd4,
        KIND_LENGTH  = 3'd5
    } record_kind_t;

    typedef struct packed {
        record_kind_t record_kind;
        logic [15:0]  first_id;
        logic [15:0]  second_id;
        logic         table_is_other;
        logic [4:0]   version_number;
        logic         current_next;
        logic [7:0]   section_number;
        logic [7:0]   last_section_number;
        logic         eit_schedule;
        logic         eit_present_following;
        logic [2:0]   service_status;
        logic         ca_scrambled;
    } record_t;

endpackage

### sv/sdt_section_parser_core.sv
// Top level: DVB service description table section parser
// Throughput: one section byte accepted every cycle while in_stall is low.
// Records are registered: result register, or skid register if out stalls.
// A two-entry output buffer (result register plus skid register) keeps input
// open while one record waits; input stalls only when both entries are full.
// Reset: async active low; parser idle, table ids 66 and 70, buffer empty.
module sdt_section_parser_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sdt_pkg::CfgIndexW-1:0]      cfg_index,
    input  logic [sdt_pkg::ByteW-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         section_byte,
    input  logic                               section_start,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [2:0]                         record_kind,
    output logic [15:0]                        first_id,
    output logic [15:0]                        second_id,
    output logic                               table_is_other,
    output logic [4:0]                         version_number,
    output logic                               current_next,
    output logic [7:0]                         section_number,
    output logic [7:0]                         last_section_number,
    output logic                               eit_schedule,
    output logic                               eit_present_following,
    output logic [2:0]                         service_status,
    output logic                               ca_scrambled
);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_SERVICE = 3'd2,
        PH_SKIP    = 3'd3,
        PH_CRC     = 3'd4
    } phase_t;

    logic [7:0]       actual_id_reg;
    logic [7:0]       other_id_reg;

    phase_t           phase_reg, phase_next;
    logic [3:0]       pos_reg, pos_next;
    logic [11:0]      bytes_left_reg, bytes_left_next;
    logic [11:0]      skip_reg, skip_next;
    logic [55:0]      hdr_reg, hdr_next;
    logic [23:0]      svc_reg, svc_next;
    logic             other_reg, other_next;

    logic             out_valid_reg;
    sdt_pkg::record_t out_rec_reg;
    logic             skid_valid_reg;
    sdt_pkg::record_t skid_rec_reg;

    logic             in_accept;
    logic             out_fire;
    logic             produce;
    sdt_pkg::record_t rec;

    logic [11:0]      bytes_dec;
    logic [11:0]      skip_dec;
    logic [11:0]      skip_full;
    logic             overrun;
    phase_t           after_svc;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_fire  = out_valid_reg && !out_stall;

    assign bytes_dec = bytes_left_reg - 12'd1;
    assign skip_dec  = skip_reg - 12'd1;
    assign skip_full = {skip_reg[11:8], section_byte};
    assign overrun   = {1'b0, bytes_dec} < (13'd4 + {1'b0, skip_full});
    assign after_svc = (bytes_dec == 12'd4) ? PH_CRC : PH_SERVICE;

    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        bytes_left_next = bytes_left_reg;
        skip_next       = skip_reg;
        hdr_next        = hdr_reg;
        svc_next        = svc_reg;
        other_next      = other_reg;
        produce         = 1'b0;
        rec             = '0;
        rec.table_is_other = other_reg;

        if (in_accept)
        begin
            if (section_start)
            begin
                if (section_byte == actual_id_reg || section_byte == other_id_reg)
                begin
                    other_next      = (section_byte != actual_id_reg);
                    phase_next      = PH_HEADER;
                    pos_next        = 4'd1;
                    bytes_left_next = '0;
                    skip_next       = '0;
                    hdr_next        = '0;
                    svc_next        = '0;
                end
                else
                begin
                    other_next         = 1'b0;
                    phase_next         = PH_IDLE;
                    produce            = 1'b1;
                    rec.record_kind    = sdt_pkg::KIND_BAD_ID;
                    rec.table_is_other = 1'b0;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (pos_reg == 4'd1)
                        begin
                            if (!section_byte[7])
                            begin
                                phase_next      = PH_IDLE;
                                produce         = 1'b1;
                                rec.record_kind = sdt_pkg::KIND_SYNTAX;
                            end
                            else
                            begin
                                bytes_left_next = {section_byte[3:0], 8'd0};
                                pos_next        = 4'd2;
                            end
                        end
                        else if (pos_reg == 4'd2)
                        begin
                            bytes_left_next = {bytes_left_reg[11:8], section_byte};
                            if ({bytes_left_reg[11:8], section_byte} < 12'd12)
                            begin
                                phase_next      = PH_IDLE;
                                produce         = 1'b1;
                                rec.record_kind = sdt_pkg::KIND_LENGTH;
                            end
                            else
                            begin
                                pos_next = 4'd3;
                            end
                        end
                        else
                        begin
                            bytes_left_next = bytes_dec;
                            if (pos_reg < 4'd10)
                            begin
                                hdr_next = {hdr_reg[47:0], section_byte};
                                pos_next = pos_reg + 4'd1;
                            end
                            else
                            begin
                                produce                 = 1'b1;
                                rec.record_kind         = sdt_pkg::KIND_HEADER;
                                rec.first_id            = hdr_reg[55:40];
                                rec.second_id           = hdr_reg[15:0];
                                rec.version_number      = hdr_reg[37:33];
                                rec.current_next        = hdr_reg[32];
                                rec.section_number      = hdr_reg[31:24];
                                rec.last_section_number = hdr_reg[23:16];
                                phase_next              = after_svc;
                                pos_next                = 4'd0;
                            end
                        end
                    end
                    PH_SERVICE:
                    begin
                        bytes_left_next = bytes_dec;
                        unique case (pos_reg)
                            4'd0:
                            begin
                                svc_next = {section_byte, 16'd0};
                                pos_next = 4'd1;
                            end
                            4'd1:
                            begin
                                svc_next = {svc_reg[23:16], section_byte, svc_reg[7:0]};
                                pos_next = 4'd2;
                            end
                            4'd2:
                            begin
                                svc_next = {svc_reg[23:8], section_byte[1:0], 6'd0};
                                pos_next = 4'd3;
                            end
                            4'd3:
                            begin
                                svc_next  = {svc_reg[23:6], section_byte[7:4], svc_reg[1:0]};
                                skip_next = {section_byte[3:0], 8'd0};
                                pos_next  = 4'd4;
                            end
                            default:
                            begin
                                skip_next = skip_full;
                                produce   = 1'b1;
                                if (overrun)
                                begin
                                    phase_next      = PH_IDLE;
                                    rec.record_kind = sdt_pkg::KIND_LENGTH;
                                end
                                else
                                begin
                                    rec.record_kind           = sdt_pkg::KIND_SERVICE;
                                    rec.first_id              = svc_reg[23:8];
                                    rec.second_id             = {4'd0, skip_full};
                                    rec.eit_schedule          = svc_reg[7];
                                    rec.eit_present_following = svc_reg[6];
                                    rec.service_status        = svc_reg[5:3];
                                    rec.ca_scrambled          = svc_reg[2];
                                    phase_next = (skip_full != 12'd0) ? PH_SKIP : after_svc;
                                    pos_next   = 4'd0;
                                end
                            end
                        endcase
                    end
                    PH_SKIP:
                    begin
                        bytes_left_next = bytes_dec;
                        skip_next       = skip_dec;
                        if (skip_dec == 12'd0)
                        begin
                            phase_next = after_svc;
                            pos_next   = 4'd0;
                        end
                    end
                    PH_CRC:
                    begin
                        bytes_left_next = bytes_dec;
                        if (bytes_dec == 12'd0)
                        begin
                            phase_next      = PH_IDLE;
                            produce         = 1'b1;
                            rec.record_kind = sdt_pkg::KIND_END;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            actual_id_reg <= sdt_pkg::ActualTableIdReset;
            other_id_reg  <= sdt_pkg::OtherTableIdReset;
        end
        else if (cfg_we)
        begin
            unique case (sdt_pkg::cfg_index_t'(cfg_index))
                sdt_pkg::CFG_ACTUAL_TABLE_ID: actual_id_reg <= cfg_data;
                sdt_pkg::CFG_OTHER_TABLE_ID:  other_id_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            pos_reg        <= '0;
            bytes_left_reg <= '0;
            skip_reg       <= '0;
            hdr_reg        <= '0;
            svc_reg        <= '0;
            other_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_rec_reg    <= '0;
            skid_valid_reg <= 1'b0;
            skid_rec_reg   <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            bytes_left_reg <= bytes_left_next;
            skip_reg       <= skip_next;
            hdr_reg        <= hdr_next;
            svc_reg        <= svc_next;
            other_reg      <= other_next;
            if (!out_valid_reg || out_fire)
            begin
                out_valid_reg  <= skid_valid_reg || produce;
                out_rec_reg    <= skid_valid_reg ? skid_rec_reg : rec;
                skid_valid_reg <= 1'b0;
            end
            else if (produce)
            begin
                skid_valid_reg <= 1'b1;
                skid_rec_reg   <= rec;
            end
        end
    end

    assign out_valid             = out_valid_reg;
    assign record_kind           = out_rec_reg.record_kind;
    assign first_id              = out_rec_reg.first_id;
    assign second_id             = out_rec_reg.second_id;
    assign table_is_other        = out_rec_reg.table_is_other;
    assign version_number        = out_rec_reg.version_number;
    assign current_next          = out_rec_reg.current_next;
    assign section_number        = out_rec_reg.section_number;
    assign last_section_number   = out_rec_reg.last_section_number;
    assign eit_schedule          = out_rec_reg.eit_schedule;
    assign eit_present_following = out_rec_reg.eit_present_following;
    assign service_status        = out_rec_reg.service_status;
    assign ca_scrambled          = out_rec_reg.ca_scrambled;

endmodule

### sv/sdt_chk.sv
// Port-level checker for the SDT section parser, bound to the top level
`include "sdt_section_parser_core_macros.svh"

module sdt_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [2:0]                    record_kind,
    input logic [15:0]                   first_id,
    input logic [15:0]                   second_id,
    input logic                          table_is_other,
    input logic [4:0]                    version_number,
    input logic                          current_next,
    input logic [7:0]                    section_number,
    input logic [7:0]                    last_section_number
);

    `SDT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(record_kind) && $stable(first_id), "stalled record changed")

    `SDT_ASSERT_SAME(a_stall_needs_record, clk, rst_n, in_stall, out_valid,
        "input stalled with no record pending")

    `SDT_ASSERT_SAME(a_bad_id_not_other, clk, rst_n,
        out_valid && record_kind == sdt_pkg::KIND_BAD_ID, !table_is_other,
        "bad table id record flags other table")

    `SDT_ASSERT_SAME(a_simple_ids_zero, clk, rst_n,
        out_valid && (record_kind == sdt_pkg::KIND_END || record_kind == sdt_pkg::KIND_BAD_ID
        || record_kind == sdt_pkg::KIND_SYNTAX || record_kind == sdt_pkg::KIND_LENGTH),
        first_id == 16'd0 && second_id == 16'd0 && version_number == 5'd0,
        "end or error record carries ids")

    `SDT_ASSERT_SAME(a_service_no_header, clk, rst_n,
        out_valid && record_kind == sdt_pkg::KIND_SERVICE,
        section_number == 8'd0 && last_section_number == 8'd0 && !current_next,
        "service record carries header fields")

endmodule

bind sdt_section_parser_core sdt_chk u_sdt_chk (.*);

### sim/tb_sdt_section_parser_core.sv
// Testbench for the SDT section parser: random sections under flow control, records checked
`timescale 1ns / 100ps

module tb_sdt_section_parser_core;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 120;

    typedef enum logic [2:0] {
        PARSE_IDLE,
        PARSE_HEADER,
        PARSE_SERVICE,
        PARSE_SKIP,
        PARSE_CRC
    } parse_phase_t;

    typedef enum logic [2:0] {
        FAULT_NONE,
        FAULT_BAD_ID,
        FAULT_SYNTAX,
        FAULT_SHORT,
        FAULT_OVERRUN,
        FAULT_TRUNCATE
    } fault_t;

    class sdt_record_scoreboard;
        sdt_pkg::record_t expected_records[$];
        int               mismatches;
        logic [7:0]       actual_id;
        logic [7:0]       other_id;
        parse_phase_t     parse_phase;
        int               pos;
        int               remaining;
        int               desc_left;
        logic [55:0]      hdr_bytes;
        logic [23:0]      svc_bits;
        logic             is_other;

        function new();
            mismatches  = 0;
            actual_id   = sdt_pkg::ActualTableIdReset;
            other_id    = sdt_pkg::OtherTableIdReset;
            parse_phase = PARSE_IDLE;
            pos         = 0;
            remaining   = 0;
            desc_left   = 0;
            hdr_bytes   = '0;
            svc_bits    = '0;
            is_other    = 1'b0;
        endfunction

        function void set_table_ids(input logic [7:0] act, input logic [7:0] oth);
            actual_id = act;
            other_id  = oth;
        endfunction

        function int pending();
            return expected_records.size();
        endfunction

        function void end_of_service();
            parse_phase = (remaining == 4) ? PARSE_CRC : PARSE_SERVICE;
            pos = 0;
        endfunction

        function void note_byte(input logic [7:0] b, input logic s);
            sdt_pkg::record_t r;
            bit               emit;
            r = '0;
            emit = 1'b0;
            if (s) begin
                if (b == actual_id) is_other = 1'b0;
                else if (b == other_id) is_other = 1'b1;
                else begin
                    is_other = 1'b0;
                    parse_phase = PARSE_IDLE;
                    r.record_kind = sdt_pkg::KIND_BAD_ID;
                    emit = 1'b1;
                end
                if (!emit) begin
                    parse_phase = PARSE_HEADER;
                    pos = 1;
                    remaining = 0;
                    desc_left = 0;
                    hdr_bytes = '0;
                    svc_bits = '0;
                end
            end else begin
                case (parse_phase)
                    PARSE_HEADER:
                        if (pos == 1) begin
                            if (!b[7]) begin
                                parse_phase = PARSE_IDLE;
                                r.record_kind = sdt_pkg::KIND_SYNTAX;
                                r.table_is_other = is_other;
                                emit = 1'b1;
                            end else begin
                                remaining = int'(b[3:0]) * 256;
                                pos = 2;
                            end
                        end else if (pos == 2) begin
                            remaining = remaining + int'(b);
                            if (remaining < 12) begin
                                parse_phase = PARSE_IDLE;
                                r.record_kind = sdt_pkg::KIND_LENGTH;
                                r.table_is_other = is_other;
                                emit = 1'b1;
                            end else begin
                                pos = 3;
                            end
                        end else begin
                            remaining = remaining - 1;
                            if (pos < 10) begin
                                hdr_bytes = {hdr_bytes[47:0], b};
                                pos = pos + 1;
                            end else begin
                                r.record_kind = sdt_pkg::KIND_HEADER;
                                r.first_id = hdr_bytes[55:40];
                                r.second_id = hdr_bytes[15:0];
                                r.table_is_other = is_other;
                                r.version_number = hdr_bytes[37:33];
                                r.current_next = hdr_bytes[32];
                                r.section_number = hdr_bytes[31:24];
                                r.last_section_number = hdr_bytes[23:16];
                                emit = 1'b1;
                                end_of_service();
                            end
                        end
                    PARSE_SERVICE: begin
                        remaining = remaining - 1;
                        if (pos == 0) begin
                            svc_bits = {b, 16'h0000};
                            pos = 1;
                        end else if (pos == 1) begin
                            svc_bits[15:8] = b;
                            pos = 2;
                        end else if (pos == 2) begin
                            svc_bits = {svc_bits[23:8], b[1:0], 6'b000000};
                            pos = 3;
                        end else if (pos == 3) begin
                            svc_bits[5:2] = b[7:4];
                            desc_left = int'(b[3:0]) * 256;
                            pos = 4;
                        end else begin
                            desc_left = desc_left + int'(b);
                            if (remaining < 4 + desc_left) begin
                                parse_phase = PARSE_IDLE;
                                r.record_kind = sdt_pkg::KIND_LENGTH;
                                r.table_is_other = is_other;
                            end else begin
                                r.record_kind = sdt_pkg::KIND_SERVICE;
                                r.first_id = svc_bits[23:8];
                                r.second_id = 16'(desc_left);
                                r.table_is_other = is_other;
                                r.eit_schedule = svc_bits[7];
                                r.eit_present_following = svc_bits[6];
                                r.service_status = svc_bits[5:3];
                                r.ca_scrambled = svc_bits[2];
                                if (desc_left != 0) begin
                                    parse_phase = PARSE_SKIP;
                                    pos = 0;
                                end else begin
                                    end_of_service();
                                end
                            end
                            emit = 1'b1;
                        end
                    end
                    PARSE_SKIP: begin
                        remaining = remaining - 1;
                        desc_left = desc_left - 1;
                        if (desc_left == 0) end_of_service();
                    end
                    PARSE_CRC: begin
                        remaining = remaining - 1;
                        if (remaining == 0) begin
                            parse_phase = PARSE_IDLE;
                            r.record_kind = sdt_pkg::KIND_END;
                            r.table_is_other = is_other;
                            emit = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (emit) expected_records.push_back(r);
        endfunction

        function string show(input sdt_pkg::record_t r);
            return $sformatf({"kind=%0d first=%h second=%h other=%0d ver=%0d cn=%0d",
                              " sec=%0d lastsec=%0d eit=%0d%0d run=%0d ca=%0d"},
                             r.record_kind, r.first_id, r.second_id, r.table_is_other,
                             r.version_number, r.current_next, r.section_number,
                             r.last_section_number, r.eit_schedule,
                             r.eit_present_following, r.service_status, r.ca_scrambled);
        endfunction

        function void check_record(input sdt_pkg::record_t got);
            sdt_pkg::record_t exp;
            bit               bad;
            if (expected_records.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected record: %s", show(got));
                return;
            end
            exp = expected_records.pop_front();
            bad = (got.record_kind !== exp.record_kind)
                || (got.first_id !== exp.first_id)
                || (got.second_id !== exp.second_id)
                || (got.table_is_other !== exp.table_is_other)
                || (got.version_number !== exp.version_number)
                || (got.current_next !== exp.current_next)
                || (got.section_number !== exp.section_number)
                || (got.last_section_number !== exp.last_section_number)
                || (got.eit_schedule !== exp.eit_schedule)
                || (got.eit_present_following !== exp.eit_present_following)
                || (got.service_status !== exp.service_status)
                || (got.ca_scrambled !== exp.ca_scrambled);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("record mismatch: expected %s", show(exp));
                    $display("                 actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    sdt_pkg::cfg_index_t       cfg_index;
    logic [sdt_pkg::ByteW-1:0] cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [7:0]                section_byte;
    logic                      section_start;
    logic                      out_valid;
    logic                      out_stall;
    logic [2:0]                record_kind;
    logic [15:0]               first_id;
    logic [15:0]               second_id;
    logic                      table_is_other;
    logic [4:0]                version_number;
    logic                      current_next;
    logic [7:0]                section_number;
    logic [7:0]                last_section_number;
    logic                      eit_schedule;
    logic                      eit_present_following;
    logic [2:0]                service_status;
    logic                      ca_scrambled;

    sdt_record_scoreboard board;
    sdt_pkg::record_t     got;
    logic [7:0]           sect_bytes[$];
    logic [7:0]           cur_actual;
    logic [7:0]           cur_other;
    int                   fill_mode;
    bit                   sender_steady;
    int                   burst_left;
    int                   bytes_sent;
    int                   cycles = 0;
    int                   stall_hold = 0;
    int                   stall_pct = 15;

    sdt_section_parser_core uut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .section_byte          (section_byte),
        .section_start         (section_start),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .record_kind           (record_kind),
        .first_id              (first_id),
        .second_id             (second_id),
        .table_is_other        (table_is_other),
        .version_number        (version_number),
        .current_next          (current_next),
        .section_number        (section_number),
        .last_section_number   (last_section_number),
        .eit_schedule          (eit_schedule),
        .eit_present_following (eit_present_following),
        .service_status        (service_status),
        .ca_scrambled          (ca_scrambled)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall) board.note_byte(section_byte, section_start);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            got.record_kind = sdt_pkg::record_kind_t'(record_kind);
            got.first_id = first_id;
            got.second_id = second_id;
            got.table_is_other = table_is_other;
            got.version_number = version_number;
            got.current_next = current_next;
            got.section_number = section_number;
            got.last_section_number = last_section_number;
            got.eit_schedule = eit_schedule;
            got.eit_present_following = eit_present_following;
            got.service_status = service_status;
            got.ca_scrambled = ca_scrambled;
            board.check_record(got);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles % 256 == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 15;
                2: stall_pct = 40;
                default: stall_pct = 75;
            endcase
        end
        if (stall_hold > 0) stall_hold--;
        else if ($urandom_range(0, 99) < stall_pct) stall_hold = $urandom_range(1, 6);
        out_stall <= (stall_hold > 0);
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_sdt_section_parser_core failed");
            $finish;
        end
    end

    function automatic logic [7:0] fill_byte();
        case (fill_mode)
            1: return 8'h00;
            2: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void build_section(input logic [7:0] tid, input int nsvc,
                                          input int maxdesc, input fault_t fault,
                                          input int aux);
        int          desc_len[8];
        int          total;
        int          tail;
        int          k;
        int          i;
        int          j;
        logic [7:0]  t;
        logic [7:0]  b1;
        logic [11:0] len_field;
        logic [11:0] loop_field;
        total = 12;
        for (i = 0; i < nsvc; i++) begin
            desc_len[i] = $urandom_range(0, maxdesc);
            total += 5 + desc_len[i];
        end
        if (fault == FAULT_SHORT) total = aux;
        len_field = 12'(total);
        k = (nsvc > 0) ? $urandom_range(0, nsvc - 1) : 0;
        t = tid;
        if (fault == FAULT_BAD_ID)
            while (t == cur_actual || t == cur_other) t = 8'($urandom_range(0, 255));
        sect_bytes.delete();
        sect_bytes.push_back(t);
        b1 = fill_byte();
        b1[7] = (fault != FAULT_SYNTAX);
        b1[3:0] = len_field[11:8];
        sect_bytes.push_back(b1);
        sect_bytes.push_back(len_field[7:0]);
        repeat (8) sect_bytes.push_back(fill_byte());
        for (i = 0; i < nsvc; i++) begin
            loop_field = 12'(desc_len[i]);
            if (fault == FAULT_OVERRUN && i == k) begin
                tail = 0;
                for (j = i + 1; j < nsvc; j++) tail += 5 + desc_len[j];
                loop_field = (aux == 1) ? 12'hFFF : 12'(desc_len[i] + tail + 1);
            end
            sect_bytes.push_back(fill_byte());
            sect_bytes.push_back(fill_byte());
            sect_bytes.push_back(fill_byte());
            b1 = fill_byte();
            b1[3:0] = loop_field[11:8];
            sect_bytes.push_back(b1);
            sect_bytes.push_back(loop_field[7:0]);
            repeat (desc_len[i]) sect_bytes.push_back(fill_byte());
        end
        repeat (4) sect_bytes.push_back(fill_byte());
        if (fault == FAULT_TRUNCATE)
            while (sect_bytes.size() > aux) void'(sect_bytes.pop_back());
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic s);
        int gap;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap = sender_steady ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        section_byte <= b;
        section_start <= s;
        bytes_sent++;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_section();
        foreach (sect_bytes[i]) send_byte(sect_bytes[i], i == 0);
    endtask

    task automatic random_section();
        int         r;
        logic [7:0] tid;
        int         nsvc;
        r = $urandom_range(0, 99);
        tid = $urandom_range(0, 1) ? cur_actual : cur_other;
        nsvc = $urandom_range(0, 3);
        fill_mode = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 2) : 0;
        sender_steady = ($urandom_range(0, 3) == 0);
        if (r < 68) begin
            build_section(tid, nsvc, ($urandom_range(0, 19) == 0) ? 40 : 6, FAULT_NONE, 0);
        end else if (r < 73) begin
            build_section(tid, nsvc, 6, FAULT_BAD_ID, 0);
        end else if (r < 78) begin
            build_section(tid, nsvc, 6, FAULT_SYNTAX, 0);
        end else if (r < 83) begin
            build_section(tid, 0, 0, FAULT_SHORT, $urandom_range(0, 11));
        end else if (r < 90) begin
            build_section(tid, $urandom_range(1, 3), 6, FAULT_OVERRUN, $urandom_range(0, 1));
        end else if (r < 96) begin
            build_section(tid, nsvc, 6, FAULT_TRUNCATE, $urandom_range(1, 40));
        end else begin
            repeat ($urandom_range(1, 8))
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            return;
        end
        send_section();
    endtask

    task automatic random_run(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) random_section();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_table_ids(input logic [7:0] act, input logic [7:0] oth);
        cfg_we <= 1'b1;
        cfg_index <= sdt_pkg::CFG_ACTUAL_TABLE_ID;
        cfg_data <= act;
        @(posedge clk);
        cfg_index <= sdt_pkg::CFG_OTHER_TABLE_ID;
        cfg_data <= oth;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_actual = act;
        cur_other = oth;
        board.set_table_ids(act, oth);
    endtask

    initial
    begin
        board = new();
        cur_actual = sdt_pkg::ActualTableIdReset;
        cur_other = sdt_pkg::OtherTableIdReset;
        fill_mode = 0;
        sender_steady = 1'b0;
        burst_left = 0;
        bytes_sent = 0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= sdt_pkg::CFG_ACTUAL_TABLE_ID;
        cfg_data <= '0;
        in_valid <= 1'b0;
        section_byte <= 8'h00;
        section_start <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        fill_mode = 1;
        build_section(sdt_pkg::ActualTableIdReset, 0, 0, FAULT_NONE, 0);
        send_section();
        fill_mode = 2;
        build_section(sdt_pkg::OtherTableIdReset, 2, 3, FAULT_NONE, 0);
        send_section();
        fill_mode = 0;
        build_section(sdt_pkg::ActualTableIdReset, 1, 2, FAULT_BAD_ID, 0);
        send_section();
        build_section(sdt_pkg::ActualTableIdReset, 1, 2, FAULT_SYNTAX, 0);
        send_section();
        build_section(sdt_pkg::OtherTableIdReset, 0, 0, FAULT_SHORT, 11);
        send_section();
        build_section(sdt_pkg::ActualTableIdReset, 0, 0, FAULT_SHORT, 0);
        send_section();
        build_section(sdt_pkg::ActualTableIdReset, 2, 3, FAULT_OVERRUN, 0);
        send_section();
        build_section(sdt_pkg::OtherTableIdReset, 1, 2, FAULT_OVERRUN, 1);
        send_section();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        build_section(sdt_pkg::ActualTableIdReset, 2, 3, FAULT_TRUNCATE, 14);
        send_section();
        build_section(sdt_pkg::OtherTableIdReset, 1, 1, FAULT_NONE, 0);
        send_section();
        random_run(PHASE_BYTES);

        drain();
        write_table_ids(8'h00, 8'hFF);
        random_run(PHASE_BYTES);

        drain();
        write_table_ids(8'h47, 8'h47);
        build_section(8'h47, 1, 2, FAULT_NONE, 0);
        send_section();
        random_run(PHASE_BYTES);

        drain();
        write_table_ids(8'hFF, 8'h00);
        random_run(PHASE_BYTES);

        drain();
        write_table_ids(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        random_run(PHASE_BYTES);

        drain();
        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb_sdt_section_parser_core passed");
        else
            $display("tb_sdt_section_parser_core failed");
        $finish;
    end

endmodule
